### rtl/cpb_pkg.sv
`timescale 1ns / 1ps

package cpb_pkg;

	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_ADD    = 2'd1;
	localparam logic [1:0] ACT_LOOKUP = 2'd2;
	localparam logic [1:0] ACT_READ   = 2'd3;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA_SHIFT  = 2'd1;

	localparam logic [7:0] MAGENTA_R = 8'd255;
	localparam logic [7:0] MAGENTA_G = 8'd0;
	localparam logic [7:0] MAGENTA_B = 8'd255;

	localparam int DIV_NUM_W = 16;
	localparam int DIV_DEN_W = 8;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] alpha;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] entry;
	} pix_item_t;

	typedef struct packed {
		logic [7:0]  index;
		logic        found;
		logic [8:0]  entries_used;
		logic        overflow;
		logic [7:0]  pal_alpha;
		logic [7:0]  pal_red;
		logic [7:0]  pal_green;
		logic [7:0]  pal_blue;
		logic [23:0] occurrences;
	} res_item_t;

endpackage

### rtl/cpb_table_mem.sv
`timescale 1ns / 1ps

module cpb_table_mem #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 56
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/cpb_divider.sv
`timescale 1ns / 1ps

module cpb_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [cpb_pkg::DIV_NUM_W-1:0] dividend,
	input  logic [cpb_pkg::DIV_DEN_W-1:0] divisor,
	output logic                          done,
	output logic [cpb_pkg::DIV_NUM_W-1:0] quotient
);

	import cpb_pkg::*;

	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   trial;
	logic                 ge;

	// One quotient bit is resolved per cycle, most significant first.
	assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
	assign ge    = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + DIV_CNT_W'(1);
			if (cnt_q == DIV_CNT_W'(DIV_NUM_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### rtl/exact_color_palette_builder.sv
`timescale 1ns / 1ps

// Exact-match RGBA palette builder with index lookup and palette readout.
// Pixel items arrive on pix_valid/pix_data and are taken when pix_stall is low.
// Each item gives exactly one result item on res_valid/res_data, held until
// res_stall is low. Configuration registers are written through cfg_we,
// cfg_index and cfg_data; the user must write them only while no item is in
// flight, since the block itself does not enforce it. Items are processed one
// at a time; pix_stall is high while an item is busy. Add and lookup scan the
// stored entries through the table memory read port at one entry per cycle.
// A palette read expands the stored alpha through the 16-step divider.
// A finished result moves into the output register, so a new item can be
// taken while that result waits on a stalled receiver; if the output
// register is still full, the block holds the result and keeps pix_stall high.
// Reset clears the entry count, the overflow flag and the configuration
// registers; the table contents need no reset since only written entries
// are ever read.

module exact_color_palette_builder #(
	parameter int PALETTE_DEPTH = 256,
	parameter int COUNT_BITS    = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pix_valid,
	output logic                           pix_stall,
	input  cpb_pkg::pix_item_t             pix_data,
	output logic                           res_valid,
	input  logic                           res_stall,
	output cpb_pkg::res_item_t             res_data,
	input  logic                           cfg_we,
	input  logic [cpb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cpb_pkg::CFG_DATA_W-1:0] cfg_data
);

	import cpb_pkg::*;

	localparam int AW = $clog2(PALETTE_DEPTH);
	localparam int CW = $clog2(PALETTE_DEPTH + 1);
	localparam int EW = 32 + COUNT_BITS;

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_SCAN    = 6'b000010,
		ST_RD_ADDR = 6'b000100,
		ST_RD_DATA = 6'b001000,
		ST_DIV     = 6'b010000,
		ST_FIN     = 6'b100000
	} state_t;

	state_t            state_q;
	logic              mode_q;
	logic [3:0]        ashift_q;
	logic [CW-1:0]     used_q;
	logic              ovf_q;
	logic [CW-1:0]     iss_q;
	logic              pend_s1;
	logic [AW-1:0]     cmp_addr_s1;
	logic [1:0]        act_q;
	logic [31:0]       key_q;
	logic [7:0]        ent_q;
	logic [7:0]        idx_q;
	logic              fnd_q;
	logic [7:0]        pa_q;
	logic [7:0]        pr_q;
	logic [7:0]        pg_q;
	logic [7:0]        pb_q;
	logic [23:0]       occ_q;
	logic              res_valid_q;
	res_item_t         res_q;

	logic              pix_acc;
	logic [7:0]        qa_pre;
	logic [7:0]        qa;
	logic [7:0]        qr;
	logic [7:0]        qg;
	logic [7:0]        qb;
	logic [CW-1:0]     cap;
	logic              scan_issue;
	logic              match;
	logic              miss_done;
	logic              res_load;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [EW-1:0]     mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [EW-1:0]     mem_rdata;
	logic [31:0]       rd_color;
	logic [COUNT_BITS-1:0]    rd_cnt;
	logic [COUNT_BITS-1:0]    cnt_inc;
	logic [COUNT_BITS+23:0]   cnt_ext;
	logic [31:0]       new_color;
	logic [3:0]        bits_w;
	logic              div_ok;
	logic [3:0]        div_sh;
	logic [7:0]        div_den;
	logic [15:0]       div_num;
	logic              div_start;
	logic              div_done;
	logic [15:0]       div_quot;

	assign pix_stall = (state_q != ST_IDLE);
	assign pix_acc   = pix_valid && !pix_stall;

	assign qa_pre = mode_q ? {4'd0, pix_data.alpha[7:4]} : pix_data.alpha;
	assign qa     = qa_pre >> ashift_q;
	assign qr     = mode_q ? {4'd0, pix_data.red[7:4]} : pix_data.red;
	assign qg     = mode_q ? {4'd0, pix_data.green[7:4]} : pix_data.green;
	assign qb     = mode_q ? {4'd0, pix_data.blue[7:4]} : pix_data.blue;

	assign cap = mode_q ? CW'(16) : CW'(PALETTE_DEPTH);

	assign rd_color = mem_rdata[EW-1 -: 32];
	assign rd_cnt   = mem_rdata[COUNT_BITS-1:0];
	assign cnt_inc  = (rd_cnt == {COUNT_BITS{1'b1}}) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
	assign cnt_ext  = {24'd0, rd_cnt};

	// A transparent pixel matches any entry whose alpha is zero.
	assign match = pend_s1 && ((key_q[31:24] == 8'd0) ? (rd_color[31:24] == 8'd0)
	                                                  : (rd_color == key_q));
	assign scan_issue = (iss_q < used_q);
	assign miss_done  = !match && !pend_s1 && !scan_issue;

	assign new_color = (key_q[31:24] == 8'd0) ? {8'd0, MAGENTA_R, MAGENTA_G, MAGENTA_B}
	                                          : key_q;

	assign bits_w  = mode_q ? 4'd4 : 4'd8;
	assign div_ok  = (ashift_q < bits_w);
	assign div_sh  = bits_w - ashift_q;
	assign div_den = 8'((9'd1 << div_sh) - 9'd1);
	assign div_num = {8'd0, rd_color[31:24]} * (mode_q ? 16'd15 : 16'd255);
	assign div_start = (state_q == ST_RD_DATA) && div_ok;

	assign res_load = (state_q == ST_FIN) && (!res_valid_q || !res_stall);

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = iss_q[AW-1:0];
		mem_we    = 1'b0;
		mem_waddr = cmp_addr_s1;
		mem_wdata = {rd_color, cnt_inc};
		case (state_q)
			ST_SCAN: begin
				mem_re = scan_issue && !match;
				if (match && act_q == ACT_ADD) begin
					mem_we = 1'b1;
				end else if (miss_done && act_q == ACT_ADD && used_q < cap) begin
					mem_we    = 1'b1;
					mem_waddr = used_q[AW-1:0];
					mem_wdata = {new_color, {COUNT_BITS{1'b0}}};
				end
			end
			ST_RD_ADDR: begin
				mem_re    = 1'b1;
				mem_raddr = ent_q[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= 1'b0;
			ashift_q    <= 4'd0;
			used_q      <= '0;
			ovf_q       <= 1'b0;
			iss_q       <= '0;
			pend_s1     <= 1'b0;
			act_q       <= ACT_CLEAR;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_CHANNEL_MODE) begin
					mode_q <= cfg_data[0];
				end else if (cfg_index == REG_ALPHA_SHIFT) begin
					ashift_q <= cfg_data;
				end
			end

			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (pix_acc) begin
						act_q   <= pix_data.action;
						iss_q   <= '0;
						pend_s1 <= 1'b0;
						case (pix_data.action)
							ACT_CLEAR: begin
								used_q  <= '0;
								ovf_q   <= 1'b0;
								state_q <= ST_FIN;
							end
							ACT_ADD, ACT_LOOKUP: begin
								state_q <= ST_SCAN;
							end
							default: begin
								if ({1'b0, pix_data.entry} < 9'(used_q)) begin
									state_q <= ST_RD_ADDR;
								end else begin
									state_q <= ST_FIN;
								end
							end
						endcase
					end
				end
				ST_SCAN: begin
					pend_s1 <= mem_re;
					if (mem_re) begin
						iss_q <= iss_q + CW'(1);
					end
					if (match) begin
						state_q <= ST_FIN;
					end else if (miss_done) begin
						if (act_q == ACT_ADD) begin
							if (used_q < cap) begin
								used_q <= used_q + CW'(1);
							end else begin
								ovf_q <= 1'b1;
							end
						end
						state_q <= ST_FIN;
					end
				end
				ST_RD_ADDR: begin
					state_q <= ST_RD_DATA;
				end
				ST_RD_DATA: begin
					state_q <= div_ok ? ST_DIV : ST_FIN;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cmp_addr_s1 <= iss_q[AW-1:0];
		if (pix_acc) begin
			key_q <= {qa, qr, qg, qb};
			ent_q <= pix_data.entry;
			idx_q <= 8'd0;
			fnd_q <= 1'b0;
			pa_q  <= 8'd0;
			pr_q  <= 8'd0;
			pg_q  <= 8'd0;
			pb_q  <= 8'd0;
			occ_q <= 24'd0;
		end
		if (state_q == ST_SCAN && match) begin
			idx_q <= 8'(cmp_addr_s1);
			fnd_q <= 1'b1;
		end
		if (state_q == ST_RD_DATA) begin
			pr_q  <= rd_color[23:16];
			pg_q  <= rd_color[15:8];
			pb_q  <= rd_color[7:0];
			occ_q <= cnt_ext[23:0];
		end
		if (state_q == ST_DIV && div_done) begin
			pa_q <= div_quot[7:0];
		end
		if (res_load) begin
			res_q.index        <= idx_q;
			res_q.found        <= fnd_q;
			res_q.entries_used <= 9'(used_q);
			res_q.overflow     <= ovf_q;
			res_q.pal_alpha    <= pa_q;
			res_q.pal_red      <= pr_q;
			res_q.pal_green    <= pg_q;
			res_q.pal_blue     <= pb_q;
			res_q.occurrences  <= occ_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	cpb_table_mem #(
		.DEPTH(PALETTE_DEPTH),
		.WIDTH(EW)
	) u_table (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	cpb_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_num),
		.divisor (div_den),
		.done    (div_done),
		.quotient(div_quot)
	);

endmodule

### tb/tb_exact_color_palette_builder.sv
`timescale 1ns / 1ps

module tb_exact_color_palette_builder;
	import cpb_pkg::*;

	localparam int DEPTH = 256;
	localparam int POOL_SIZE = 12;
	localparam int PHASE_ITEMS = 175;
	localparam int STALL_LIMIT = 4000;
	localparam logic [23:0] COUNT_CEIL = 24'hFFFFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pix_valid = 1'b0;
	logic pix_stall;
	pix_item_t pix_data = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_item_t res_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	exact_color_palette_builder u_top (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pix_data(pix_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data(res_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	logic [7:0] pal_a [DEPTH];
	logic [7:0] pal_r [DEPTH];
	logic [7:0] pal_g [DEPTH];
	logic [7:0] pal_b [DEPTH];
	logic [23:0] pal_hits [DEPTH];
	int pal_used = 0;
	logic pal_overflow = 1'b0;
	logic pal_mode = 1'b0;
	logic [3:0] pal_shift = '0;

	pix_item_t pending_pixels [$];
	res_item_t expected_results [$];
	res_item_t want;
	int items_queued = 0;
	int results_seen = 0;
	int errors = 0;
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	int quiet_cycles = 0;

	function automatic res_item_t predict_palette_result(pix_item_t px);
		res_item_t r;
		int qs;
		int hit;
		int i;
		int cap;
		int bits;
		int full;
		int divisor;
		int unsigned expanded;
		logic [7:0] qa;
		logic [7:0] qr;
		logic [7:0] qg;
		logic [7:0] qb;
		r = '0;
		qs = pal_mode ? 4 : 0;
		qa = (px.alpha >> qs) >> pal_shift;
		qr = px.red >> qs;
		qg = px.green >> qs;
		qb = px.blue >> qs;
		case (px.action)
			ACT_CLEAR: begin
				pal_used = 0;
				pal_overflow = 1'b0;
			end
			ACT_ADD, ACT_LOOKUP: begin
				hit = -1;
				for (i = 0; i < pal_used && hit < 0; i++) begin
					if (qa == 8'd0) begin
						if (pal_a[i] == 8'd0)
							hit = i;
					end else if (pal_a[i] == qa && pal_r[i] == qr && pal_g[i] == qg &&
							pal_b[i] == qb) begin
						hit = i;
					end
				end
				if (hit >= 0) begin
					r.index = hit[7:0];
					r.found = 1'b1;
					if (px.action == ACT_ADD && pal_hits[hit] != COUNT_CEIL)
						pal_hits[hit] = pal_hits[hit] + 24'd1;
				end else if (px.action == ACT_ADD) begin
					cap = pal_mode ? 16 : DEPTH;
					if (pal_used < cap) begin
						pal_a[pal_used] = qa;
						pal_r[pal_used] = (qa == 8'd0) ? MAGENTA_R : qr;
						pal_g[pal_used] = (qa == 8'd0) ? MAGENTA_G : qg;
						pal_b[pal_used] = (qa == 8'd0) ? MAGENTA_B : qb;
						pal_hits[pal_used] = '0;
						pal_used++;
					end else begin
						pal_overflow = 1'b1;
					end
				end
			end
			default: begin
				if (int'(px.entry) < pal_used) begin
					bits = pal_mode ? 4 : 8;
					full = pal_mode ? 15 : 255;
					expanded = 0;
					if (int'(pal_shift) < bits) begin
						divisor = (1 << (bits - int'(pal_shift))) - 1;
						if (divisor != 0)
							expanded = (pal_a[px.entry] * full) / divisor;
					end
					r.pal_alpha = expanded[7:0];
					r.pal_red = pal_r[px.entry];
					r.pal_green = pal_g[px.entry];
					r.pal_blue = pal_b[px.entry];
					r.occurrences = pal_hits[px.entry];
				end
			end
		endcase
		r.entries_used = pal_used[8:0];
		r.overflow = pal_overflow;
		return r;
	endfunction

	task automatic compare_field(string name, logic [23:0] exp_val, logic [23:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_val,
				act_val);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
		end else begin
			if (pix_valid && !pix_stall)
				expected_results.insert(expected_results.size(),
					predict_palette_result(pix_data));
			if (!pix_valid || !pix_stall) begin
				if (pending_pixels.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
					pix_valid <= 1'b1;
					pix_data <= pending_pixels.pop_front();
				end else begin
					pix_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with no item pending: expected none, actual %p",
						$time, res_data);
					errors++;
				end else begin
					want = expected_results.pop_front();
					compare_field("index", 24'(want.index), 24'(res_data.index));
					compare_field("found", 24'(want.found), 24'(res_data.found));
					compare_field("entries_used", 24'(want.entries_used),
						24'(res_data.entries_used));
					compare_field("overflow", 24'(want.overflow), 24'(res_data.overflow));
					compare_field("pal_alpha", 24'(want.pal_alpha), 24'(res_data.pal_alpha));
					compare_field("pal_red", 24'(want.pal_red), 24'(res_data.pal_red));
					compare_field("pal_green", 24'(want.pal_green), 24'(res_data.pal_green));
					compare_field("pal_blue", 24'(want.pal_blue), 24'(res_data.pal_blue));
					compare_field("occurrences", want.occurrences, res_data.occurrences);
					results_seen++;
				end
			end
			res_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((pix_valid && !pix_stall) || (res_valid && !res_stall) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CHANNEL_MODE: pal_mode = val[0];
			REG_ALPHA_SHIFT: pal_shift = val;
			default: ;
		endcase
	endtask

	task automatic push_pixel(logic [1:0] act, logic [7:0] a, logic [7:0] r, logic [7:0] g,
			logic [7:0] b, logic [7:0] e);
		pix_item_t px;
		px.action = act;
		px.alpha = a;
		px.red = r;
		px.green = g;
		px.blue = b;
		px.entry = e;
		pending_pixels.insert(pending_pixels.size(), px);
		items_queued++;
	endtask

	task automatic drain_results();
		while (results_seen < items_queued)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int ph;
		int k;
		int pick;
		int slot;
		logic [1:0] act;
		logic [7:0] a;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] e;
		logic [7:0] pool_a [POOL_SIZE];
		logic [7:0] pool_r [POOL_SIZE];
		logic [7:0] pool_g [POOL_SIZE];
		logic [7:0] pool_b [POOL_SIZE];

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		snd_idle_pct = 22;
		rcv_idle_pct = 64;
		write_reg(REG_CHANNEL_MODE, 4'd0);
		write_reg(REG_ALPHA_SHIFT, 4'd0);

		push_pixel(ACT_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		push_pixel(ACT_LOOKUP, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00);
		push_pixel(ACT_ADD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00);
		push_pixel(ACT_ADD, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		push_pixel(ACT_ADD, 8'h00, 8'h12, 8'h34, 8'h56, 8'h00);
		push_pixel(ACT_ADD, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00);
		push_pixel(ACT_LOOKUP, 8'h00, 8'hAB, 8'hCD, 8'hEF, 8'h00);
		push_pixel(ACT_ADD, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00);
		push_pixel(ACT_ADD, 8'h80, 8'h55, 8'hAA, 8'h55, 8'h00);
		push_pixel(ACT_LOOKUP, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00);
		push_pixel(ACT_LOOKUP, 8'h80, 8'h55, 8'hAA, 8'h54, 8'h00);
		for (k = 0; k < 5; k++)
			push_pixel(ACT_READ, 8'h00, 8'h00, 8'h00, 8'h00, k[7:0]);
		push_pixel(ACT_READ, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		push_pixel(ACT_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		push_pixel(ACT_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		push_pixel(ACT_LOOKUP, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		push_pixel(ACT_ADD, 8'h7F, 8'hAA, 8'h55, 8'hAA, 8'h00);
		push_pixel(ACT_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		drain_results();

		// Fill the full 8-bit table, then push past it to raise the overflow flag.
		push_pixel(ACT_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		for (k = 0; k < DEPTH + 4; k++)
			push_pixel(ACT_ADD, 8'hFF, k[7:0], {7'd0, k[8]}, k[7:0] ^ 8'h5A, 8'h00);
		for (k = 0; k < 4; k++)
			push_pixel(ACT_ADD, 8'hFF, k[7:0], 8'h00, k[7:0] ^ 8'h5A, 8'h00);
		push_pixel(ACT_ADD, 8'h00, 8'h11, 8'h22, 8'h33, 8'h00);
		push_pixel(ACT_LOOKUP, 8'hFF, 8'hFF, 8'h00, 8'hA5, 8'h00);
		push_pixel(ACT_LOOKUP, 8'hFF, 8'h00, 8'h00, 8'h5A, 8'h00);
		push_pixel(ACT_LOOKUP, 8'hFF, 8'h00, 8'h01, 8'h5A, 8'h00);
		push_pixel(ACT_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
		push_pixel(ACT_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80);
		push_pixel(ACT_READ, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF);
		drain_results();

		for (ph = 0; ph < 9; ph++) begin
			if (ph < 3) begin
				snd_idle_pct = 22;
				rcv_idle_pct = 64;
			end else if (ph < 6) begin
				snd_idle_pct = 64;
				rcv_idle_pct = 22;
			end else begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
			write_reg(REG_CHANNEL_MODE, {3'd0, ~ph[0]});
			write_reg(REG_ALPHA_SHIFT, 4'((ph * 5) % 9));
			for (k = 0; k < POOL_SIZE; k++) begin
				pool_a[k] = 8'($urandom_range(255));
				pool_r[k] = 8'($urandom_range(255));
				pool_g[k] = 8'($urandom_range(255));
				pool_b[k] = 8'($urandom_range(255));
			end
			for (k = 0; k < PHASE_ITEMS; k++) begin
				pick = $urandom_range(99);
				if (pick < 4)
					act = ACT_CLEAR;
				else if (pick < 50)
					act = ACT_ADD;
				else if (pick < 80)
					act = ACT_LOOKUP;
				else
					act = ACT_READ;
				slot = $urandom_range(POOL_SIZE - 1);
				pick = $urandom_range(99);
				if (pick < 60) begin
					a = pool_a[slot];
					r = pool_r[slot];
					g = pool_g[slot];
					b = pool_b[slot];
					if (pick < 15) begin
						a[3:0] = 4'($urandom_range(15));
						r[3:0] = 4'($urandom_range(15));
						g[3:0] = 4'($urandom_range(15));
						b[3:0] = 4'($urandom_range(15));
					end
				end else begin
					a = (pick < 75) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
					r = 8'($urandom_range(255));
					g = 8'($urandom_range(255));
					b = 8'($urandom_range(255));
				end
				e = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) :
					8'($urandom_range(24));
				push_pixel(act, a, r, g, b, e);
			end
			drain_results();
		end

		repeat (DEPTH + 8) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
